@@ src/dse_pkg.sv @@
package dse_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int SLOT_W  = 6;
   localparam int CNT_W   = 7;
   localparam int TIME_W  = 32;
   localparam int KIND_W  = 2;
   localparam int CSR_W   = 2;

   localparam logic [KIND_W-1:0] KIND_DECODED = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TOUCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

   localparam logic [CSR_W-1:0] CSR_CAP    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_TARGET = 2'd1;
   localparam logic [CSR_W-1:0] CSR_GRACE  = 2'd2;

   localparam logic [CNT_W-1:0]  CAP_RESET    = 7'd48;
   localparam logic [CNT_W-1:0]  TARGET_RESET = 7'd42;
   localparam logic [TIME_W-1:0] GRACE_RESET  = 32'd5000;

   typedef struct packed {
      logic load_item;
      logic exec_single;
      logic exec_clear;
      logic scan_start;
      logic free_best;
      logic emit_pending;
      logic emit_final;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              out_free;
      logic              scan_done;
      logic              found;
      logic              pass_active;
      logic              after_le_target;
      logic              pend_valid;
   } sts_type;

endpackage

@@ src/dse_channels.sv @@
interface dse_req_if import dse_pkg::*;;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [5:0]        entry;
   logic [TIME_W-1:0] now_ms;
   modport source (output valid, kind, entry, now_ms, input ready);
   modport sink   (input valid, kind, entry, now_ms, output ready);
endinterface

interface dse_rsp_if import dse_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic              released;
   logic [CNT_W-1:0]  decoded_count;
   logic              last;
   modport source (output valid, slot, released, decoded_count, last, input ready);
   modport sink   (input valid, slot, released, decoded_count, last, output ready);
endinterface

interface dse_csr_if import dse_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CSR_W-1:0]  index;
   logic [TIME_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/decoded_sheet_eviction_unit.sv @@
// Decoded-sheet table with least-recently-used release between a cap and a
// target count. The block takes one item at a time. Decoded, touch and clear
// items are loaded at accept and register their result from the execute step,
// which waits for a free result register, and the block is then ready again.
// A release pass reads the last-use memory through its single read port, one
// entry per cycle, so each released entry costs a scan of all ENTRIES entries
// and a decision. After each release the pass scans again unless the count is
// at or below the target, and it stops when no entry is eligible. A pass that
// does not act goes straight to its final result. A released result is held
// until the block knows whether it is the last, and a stalled result holds
// the pass at its decision step. Configuration writes are always taken and
// must arrive only while idle.
module decoded_sheet_eviction_unit import dse_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dse_req_if.sink   req_bus,
   dse_rsp_if.source rsp_bus,
   dse_csr_if.sink   csr_bus
);

   cmd_type cmd;
   sts_type sts;
   logic    ready;

   assign req_bus.ready = ready;

   dse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dse_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

endmodule

@@ src/dse_ctrl.sv @@
module dse_ctrl import dse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.kind)
               KIND_DECODED, KIND_TOUCH: begin
                  if (sts.out_free) begin
                     cmd.exec_single = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end
               KIND_CLEAR: begin
                  if (sts.out_free) begin
                     cmd.exec_clear = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end
               default: begin
                  if (sts.pass_active) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.found) begin
               state_in = ST_FLUSH;
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.emit_pending = sts.pend_valid;
               cmd.free_best    = 1'b1;
               if (sts.after_le_target) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/dse_datapath.sv @@
module dse_datapath import dse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dse_req_if.sink     req_bus,
   dse_rsp_if.source   rsp_bus,
   dse_csr_if.sink     csr_bus,
   input  cmd_type     cmd,
   output sts_type     sts
);

   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  target_ff;
   logic [TIME_W-1:0] grace_ff;

   logic [KIND_W-1:0] kind_ff;
   logic [5:0]        entry_ff;
   logic [TIME_W-1:0] now_ff;

   logic [ENTRIES-1:0] mark_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [TIME_W-1:0]  use_mem [ENTRIES];
   logic [TIME_W-1:0]  rd_data_ff;

   logic [IDX_W-1:0]  addr_ff;
   logic              issue_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_valid_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TIME_W-1:0] best_age_ff;
   logic              best_valid_ff;

   logic [IDX_W-1:0]  pend_slot_ff;
   logic [CNT_W-1:0]  pend_cnt_ff;
   logic              pend_valid_ff;

   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_released_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0]  entry_idx;
   logic              entry_ok;
   logic              entry_marked;
   logic              use_wr;
   logic [TIME_W-1:0] age;
   logic              eligible;
   logic              better;
   logic [CNT_W-1:0]  count_dec;
   logic [CNT_W-1:0]  count_single;

   assign entry_idx    = IDX_W'(entry_ff);
   assign entry_ok     = ({1'b0, entry_ff} < CNT_W'(ENTRIES));
   assign entry_marked = mark_ff[entry_idx];
   assign use_wr       = cmd.exec_single && entry_ok &&
                         ((kind_ff == KIND_DECODED) || entry_marked);
   assign count_single = (cmd.exec_single && entry_ok && (kind_ff == KIND_DECODED) &&
                          !entry_marked) ? count_ff + 1'b1 : count_ff;
   assign count_dec    = count_ff - 1'b1;

   assign age      = now_ff - rd_data_ff;
   assign eligible = mark_ff[cmp_idx_ff] && (age > grace_ff);
   assign better   = eligible && (!best_valid_ff || (age > best_age_ff));

   assign csr_bus.ready = 1'b1;

   assign sts.kind            = kind_ff;
   assign sts.out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign sts.scan_done       = cmp_valid_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1));
   assign sts.found           = best_valid_ff;
   assign sts.pass_active     = (count_ff > cap_ff) && (count_ff > target_ff);
   assign sts.after_le_target = (count_dec <= target_ff);
   assign sts.pend_valid      = pend_valid_ff;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.slot          = rsp_slot_ff;
   assign rsp_bus.released      = rsp_released_ff;
   assign rsp_bus.decoded_count = rsp_count_ff;
   assign rsp_bus.last          = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (use_wr) begin
         use_mem[entry_idx] <= now_ff;
      end
      rd_data_ff <= use_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff  <= req_bus.kind;
         entry_ff <= req_bus.entry;
         now_ff   <= req_bus.now_ms;
      end
      if (issue_ff) begin
         cmp_idx_ff <= addr_ff;
      end
      if (cmp_valid_ff && better) begin
         best_idx_ff <= cmp_idx_ff;
         best_age_ff <= age;
      end
      if (cmd.free_best) begin
         pend_slot_ff <= best_idx_ff;
         pend_cnt_ff  <= count_dec;
      end
      if (cmd.exec_single) begin
         rsp_slot_ff     <= SLOT_W'(entry_ff);
         rsp_released_ff <= 1'b0;
         rsp_count_ff    <= count_single;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.exec_clear) begin
         rsp_slot_ff     <= '0;
         rsp_released_ff <= 1'b0;
         rsp_count_ff    <= '0;
         rsp_last_ff     <= 1'b1;
      end else if (cmd.emit_pending) begin
         rsp_slot_ff     <= SLOT_W'(pend_slot_ff);
         rsp_released_ff <= 1'b1;
         rsp_count_ff    <= pend_cnt_ff;
         rsp_last_ff     <= 1'b0;
      end else if (cmd.emit_final) begin
         rsp_slot_ff     <= pend_valid_ff ? SLOT_W'(pend_slot_ff) : '0;
         rsp_released_ff <= pend_valid_ff;
         rsp_count_ff    <= pend_valid_ff ? pend_cnt_ff : count_ff;
         rsp_last_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         target_ff     <= TARGET_RESET;
         grace_ff      <= GRACE_RESET;
         mark_ff       <= '0;
         count_ff      <= '0;
         addr_ff       <= '0;
         issue_ff      <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_CAP:    cap_ff    <= CNT_W'(csr_bus.data);
               CSR_TARGET: target_ff <= CNT_W'(csr_bus.data);
               CSR_GRACE:  grace_ff  <= csr_bus.data;
               default: begin
               end
            endcase
         end

         if (cmd.exec_single && entry_ok && (kind_ff == KIND_DECODED)) begin
            mark_ff[entry_idx] <= 1'b1;
         end
         if (cmd.exec_clear) begin
            mark_ff <= '0;
         end
         if (cmd.free_best) begin
            mark_ff[best_idx_ff] <= 1'b0;
         end

         if (cmd.exec_clear) begin
            count_ff <= '0;
         end else if (cmd.free_best) begin
            count_ff <= count_dec;
         end else if (cmd.exec_single) begin
            count_ff <= count_single;
         end

         if (cmd.scan_start) begin
            addr_ff       <= '0;
            issue_ff      <= 1'b1;
            best_valid_ff <= 1'b0;
         end else if (issue_ff) begin
            addr_ff <= addr_ff + 1'b1;
            if (addr_ff == IDX_W'(ENTRIES - 1)) begin
               issue_ff <= 1'b0;
            end
         end
         if (cmp_valid_ff && better) begin
            best_valid_ff <= 1'b1;
         end
         cmp_valid_ff <= issue_ff && !cmd.scan_start;

         if (cmd.load_item || cmd.emit_final) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.free_best) begin
            pend_valid_ff <= 1'b1;
         end

         if (cmd.exec_single || cmd.exec_clear || cmd.emit_pending || cmd.emit_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ src/dse_checker.sv @@
module dse_checker import dse_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [SLOT_W-1:0] rsp_slot,
   input logic              rsp_released,
   input logic [CNT_W-1:0]  rsp_count,
   input logic              rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_slot) && $stable(rsp_released) &&
         $stable(rsp_count) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_released |-> rsp_last)
      else $error("non-release result not marked last");

   a_release_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_released |-> rsp_count < CNT_W'(ENTRIES))
      else $error("count after release out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item in flight");

endmodule

bind decoded_sheet_eviction_unit dse_checker u_dse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_slot     (rsp_bus.slot),
   .rsp_released (rsp_bus.released),
   .rsp_count    (rsp_bus.decoded_count),
   .rsp_last     (rsp_bus.last)
);
